>>> hw/rtl/cycled_layout_subvolume_copy_addr_assert.svh
// assertion macros used by the copy address generator
`ifndef CYCLED_LAYOUT_SUBVOLUME_COPY_ADDR_ASSERT_SVH
`define CYCLED_LAYOUT_SUBVOLUME_COPY_ADDR_ASSERT_SVH

// same-cycle implication, held off during reset
`define CLSC_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define CLSC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/clsc_pkg.sv
// shared types and constants of the copy address generator
package clsc_pkg;

    localparam int MAX_DIM_DEF = 1024;

    localparam int FIELD_W    = 11;
    localparam int ORG_W      = 10;
    localparam int EXT_W      = 11;
    localparam int IDX_W      = 30;
    localparam int LAYOUT_W   = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 11;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 64;

    // register reset values
    localparam logic [FIELD_W-1:0] FIELD_W_RST = FIELD_W'(64);
    localparam logic [FIELD_W-1:0] FIELD_H_RST = FIELD_W'(64);
    localparam logic [ORG_W-1:0]   ORIGIN_RST  = '0;
    localparam logic [EXT_W-1:0]   EXTENT_RST  = EXT_W'(8);

    // configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FIELD_WIDTH  = 3'd0,
        REG_FIELD_HEIGHT = 3'd1,
        REG_ORIGIN_X     = 3'd2,
        REG_ORIGIN_Y     = 3'd3,
        REG_ORIGIN_Z     = 3'd4,
        REG_EXTENT_X     = 3'd5,
        REG_EXTENT_Y     = 3'd6,
        REG_EXTENT_Z     = 3'd7
    } t_cfg_reg;

    // brick layouts, named slowest to fastest axis
    typedef enum logic [LAYOUT_W-1:0] {
        LAYOUT_ZYX = 2'd0,
        LAYOUT_XZY = 2'd1,
        LAYOUT_YXZ = 2'd2
    } t_layout;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL1 = 4'b0010,
        S_MUL2 = 4'b0100,
        S_PUSH = 4'b1000
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic mul1_en;
        logic mul2_en;
        logic load_out;
    } t_ctrl;

    // datapath to controller status
    typedef struct packed {
        logic will_emit;
        logic out_free;
    } t_stat;

endpackage

>>> hw/rtl/clsc_ctrl.sv
// controller state machine sequencing one word through the datapath
module clsc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  clsc_pkg::t_stat i_stat,
    output clsc_pkg::t_ctrl o_cmd
);
    import clsc_pkg::*;

    t_state r_state;
    t_state n_state;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_stat.will_emit) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_PUSH;
            S_PUSH: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // commands
    assign o_in_ready       = (r_state == S_IDLE);
    assign o_cmd.accept     = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.mul1_en    = (r_state == S_MUL1);
    assign o_cmd.mul2_en    = (r_state == S_MUL2);
    assign o_cmd.load_out   = (r_state == S_PUSH) && i_stat.out_free;

endmodule

>>> hw/rtl/clsc_dp.sv
// datapath: config registers, loop counters, index multipliers, output register
module clsc_dp #(
    parameter int MAX_DIM = clsc_pkg::MAX_DIM_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [clsc_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [clsc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_restart,
    input  logic [clsc_pkg::LAYOUT_W-1:0]    i_layout,
    input  clsc_pkg::t_ctrl                  i_cmd,
    output clsc_pkg::t_stat                  o_stat,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [clsc_pkg::IDX_W-1:0]       o_src_index,
    output logic [clsc_pkg::IDX_W-1:0]       o_dst_index,
    output logic                             o_last
);
    import clsc_pkg::*;

    localparam int CNT_W = (MAX_DIM >= 2048) ? EXT_W : $clog2(MAX_DIM);
    localparam int SUM_W = ((CNT_W > ORG_W) ? CNT_W : ORG_W) + 1;
    localparam int S1_W  = SUM_W + FIELD_W + 1;
    localparam int PS_W  = S1_W + FIELD_W;
    localparam int D1_W  = CNT_W + EXT_W + 1;
    localparam int PD_W  = D1_W + EXT_W;
    localparam int CMP_W = EXT_W + 1;
    localparam int LIM_W = ($clog2(MAX_DIM + 1) > EXT_W) ? $clog2(MAX_DIM + 1) : EXT_W;

    // extent 0 reads as 1, above the maximum reads as the maximum
    function automatic logic [EXT_W-1:0] clamp_ext(input logic [EXT_W-1:0] e);
        logic [EXT_W-1:0] r;
        if (e == '0) begin
            r = EXT_W'(1);
        end else if (LIM_W'(e) > LIM_W'(MAX_DIM)) begin
            r = EXT_W'(MAX_DIM);
        end else begin
            r = e;
        end
        return r;
    endfunction

    logic [FIELD_W-1:0] r_fw, r_fh;
    logic [ORG_W-1:0]   r_ox, r_oy, r_oz;
    logic [EXT_W-1:0]   r_ex, r_ey, r_ez;

    t_layout            r_layout;
    logic               r_busy;
    logic [CNT_W-1:0]   r_cx, r_cy, r_cz;

    logic [S1_W-1:0]    r_s1;
    logic [D1_W-1:0]    r_d1;
    logic [IDX_W-1:0]   r_res_src, r_res_dst;
    logic               r_res_last;

    logic               r_out_valid;
    logic [IDX_W-1:0]   r_out_src, r_out_dst;
    logic               r_out_last;

    logic [EXT_W-1:0]   w_ex, w_ey, w_ez;
    logic [SUM_W-1:0]   w_sx, w_sy, w_sz;
    logic [CNT_W-1:0]   w_f, w_m, w_o;
    logic [EXT_W-1:0]   w_ef, w_em, w_eo;
    logic [CMP_W-1:0]   w_f_inc, w_m_inc, w_o_inc;
    logic               w_f_end, w_m_end, w_o_end;
    logic [CNT_W-1:0]   w_nf, w_nm, w_no;
    logic [CNT_W-1:0]   n_cx, n_cy, n_cz;
    logic               w_done;
    logic [S1_W-1:0]    w_s1;
    logic [D1_W-1:0]    w_d1;
    logic [PS_W-1:0]    w_src_full;
    logic [PD_W-1:0]    w_dst_full;
    t_layout            w_new_layout;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= FIELD_W_RST;
            r_fh <= FIELD_H_RST;
            r_ox <= ORIGIN_RST;
            r_oy <= ORIGIN_RST;
            r_oz <= ORIGIN_RST;
            r_ex <= EXTENT_RST;
            r_ey <= EXTENT_RST;
            r_ez <= EXTENT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                REG_FIELD_WIDTH:  r_fw <= i_cfg_data[FIELD_W-1:0];
                REG_FIELD_HEIGHT: r_fh <= i_cfg_data[FIELD_W-1:0];
                REG_ORIGIN_X:     r_ox <= i_cfg_data[ORG_W-1:0];
                REG_ORIGIN_Y:     r_oy <= i_cfg_data[ORG_W-1:0];
                REG_ORIGIN_Z:     r_oz <= i_cfg_data[ORG_W-1:0];
                REG_EXTENT_X:     r_ex <= i_cfg_data[EXT_W-1:0];
                REG_EXTENT_Y:     r_ey <= i_cfg_data[EXT_W-1:0];
                REG_EXTENT_Z:     r_ez <= i_cfg_data[EXT_W-1:0];
                default: ;
            endcase
        end
    end

    // effective extents and source coordinates
    assign w_ex = clamp_ext(r_ex);
    assign w_ey = clamp_ext(r_ey);
    assign w_ez = clamp_ext(r_ez);
    assign w_sx = SUM_W'(r_ox) + SUM_W'(r_cx);
    assign w_sy = SUM_W'(r_oy) + SUM_W'(r_cy);
    assign w_sz = SUM_W'(r_oz) + SUM_W'(r_cz);

    // map counters to fastest, middle, outer loop of the layout
    always_comb begin
        unique case (r_layout)
            LAYOUT_XZY: begin
                w_f = r_cy; w_m = r_cz; w_o = r_cx;
                w_ef = w_ey; w_em = w_ez; w_eo = w_ex;
            end
            LAYOUT_YXZ: begin
                w_f = r_cz; w_m = r_cx; w_o = r_cy;
                w_ef = w_ez; w_em = w_ex; w_eo = w_ey;
            end
            default: begin
                w_f = r_cx; w_m = r_cy; w_o = r_cz;
                w_ef = w_ex; w_em = w_ey; w_eo = w_ez;
            end
        endcase
    end

    // three-level counter advance
    assign w_f_inc = CMP_W'(w_f) + CMP_W'(1);
    assign w_m_inc = CMP_W'(w_m) + CMP_W'(1);
    assign w_o_inc = CMP_W'(w_o) + CMP_W'(1);
    assign w_f_end = (w_f_inc >= CMP_W'(w_ef));
    assign w_m_end = (w_m_inc >= CMP_W'(w_em));
    assign w_o_end = (w_o_inc >= CMP_W'(w_eo));
    assign w_nf    = w_f_end ? '0 : w_f_inc[CNT_W-1:0];
    assign w_nm    = !w_f_end ? w_m : (w_m_end ? '0 : w_m_inc[CNT_W-1:0]);
    assign w_no    = !(w_f_end && w_m_end) ? w_o : (w_o_end ? '0 : w_o_inc[CNT_W-1:0]);
    assign w_done  = w_f_end && w_m_end && w_o_end;

    // map advanced counters back to axes
    always_comb begin
        unique case (r_layout)
            LAYOUT_XZY: begin
                n_cy = w_nf; n_cz = w_nm; n_cx = w_no;
            end
            LAYOUT_YXZ: begin
                n_cz = w_nf; n_cx = w_nm; n_cy = w_no;
            end
            default: begin
                n_cx = w_nf; n_cy = w_nm; n_cz = w_no;
            end
        endcase
    end

    // first and second multiply of each index
    assign w_s1       = S1_W'(w_sz) * S1_W'(r_fh) + S1_W'(w_sy);
    assign w_d1       = D1_W'(w_o) * D1_W'(w_em) + D1_W'(w_m);
    assign w_src_full = PS_W'(r_s1) * PS_W'(r_fw) + PS_W'(w_sx);
    assign w_dst_full = PD_W'(r_d1) * PD_W'(w_ef) + PD_W'(w_f);

    assign w_new_layout = (i_layout == 2'd3) ? LAYOUT_ZYX : t_layout'(i_layout);

    // copy state: restart on accept, advance after the second multiply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout <= LAYOUT_ZYX;
            r_busy   <= 1'b0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_cz     <= '0;
        end else if (i_cmd.accept && i_restart) begin
            r_layout <= w_new_layout;
            r_busy   <= 1'b1;
            r_cx     <= '0;
            r_cy     <= '0;
            r_cz     <= '0;
        end else if (i_cmd.mul2_en) begin
            r_cx <= n_cx;
            r_cy <= n_cy;
            r_cz <= n_cz;
            if (w_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    // pipeline payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1_en) begin
            r_s1 <= w_s1;
            r_d1 <= w_d1;
        end
        if (i_cmd.mul2_en) begin
            r_res_src  <= w_src_full[IDX_W-1:0];
            r_res_dst  <= IDX_W'(w_dst_full);
            r_res_last <= w_done;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_src  <= r_res_src;
            r_out_dst  <= r_res_dst;
            r_out_last <= r_res_last;
        end
    end

    assign o_stat.will_emit = i_restart || r_busy;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_src_index      = r_out_src;
    assign o_dst_index      = r_out_dst;
    assign o_last           = r_out_last;

endmodule

>>> hw/rtl/cycled_layout_subvolume_copy_addr.sv
// top level of the strided 3d sub-box copy address generator
//
// Walks a box of the configured extent at the configured origin inside an
// x-fastest source volume and emits one (src_index, dst_index) word per input
// word, in the loop order of the brick layout latched by the last restart
// word (0 x fastest, 1 y fastest, 2 z fastest, 3 reads as 0). The restart
// word itself emits the first pair; tlast marks the final pair, and words
// after it emit nothing until the next restart. A word that emits a pair
// holds the input through accept, two registered multiply stages for the
// two chained products of each index, and output load, which waits while
// the output register is held and m_axis_tready is low; a word that emits
// nothing is accepted without leaving idle. The controller handles one word
// at a time. Config writes land at once and are meant for idle periods.
`include "cycled_layout_subvolume_copy_addr_assert.svh"

module cycled_layout_subvolume_copy_addr #(
    parameter int MAX_DIM = clsc_pkg::MAX_DIM_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write port
    input  logic                              i_cfg_we,
    input  logic [clsc_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [clsc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input word stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [clsc_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // [1:0] layout, rest zero
    input  logic                              s_axis_tuser,  // [0] restart
    // address pair stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [clsc_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // [29:0] src_index,
                                                             // [59:30] dst_index, rest zero
    output logic                              m_axis_tlast
);
    import clsc_pkg::*;

    t_ctrl              w_cmd;
    t_stat              w_stat;
    logic [IDX_W-1:0]   w_src_index;
    logic [IDX_W-1:0]   w_dst_index;

    // controller
    clsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // datapath
    clsc_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_restart   (s_axis_tuser),
        .i_layout    (s_axis_tdata[LAYOUT_W-1:0]),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_src_index (w_src_index),
        .o_dst_index (w_dst_index),
        .o_last      (m_axis_tlast)
    );

    // output word packing
    assign m_axis_tdata = {(M_TDATA_W - 2 * IDX_W)'(0), w_dst_index, w_src_index};

    // checks on sequencing
    `CLSC_ASSERT_IMPLY(a_cmd_exclusive, i_clk, i_rst_n, 1'b1, $onehot0(w_cmd), "overlapping datapath commands")
    `CLSC_ASSERT_NEXT(a_emit_starts_mul, i_clk, i_rst_n, w_cmd.accept && w_stat.will_emit, w_cmd.mul1_en, "emitting word did not enter multiply")
    `CLSC_ASSERT_NEXT(a_mul_chain, i_clk, i_rst_n, w_cmd.mul1_en, w_cmd.mul2_en, "second multiply stage skipped")
    `CLSC_ASSERT_IMPLY(a_load_no_overwrite, i_clk, i_rst_n, w_cmd.load_out, !m_axis_tvalid || m_axis_tready, "output register overwritten while held")

endmodule
